// ===== rtl/core/sfa_pkg.sv =====
// ----------------------------------------------------------------------------
// sfa_pkg - shared types and constants for the SPI transmit slot arbiter
// Holds the transaction structs, the operation and source codes, slot status
// codes and the default slot layout.
// ----------------------------------------------------------------------------
package sfa_pkg;

	// Default slot layout
	localparam int CLIENT_SLOTS_DEF = 8;
	localparam int SENSOR_SLOTS_DEF = 6;
	localparam int ONBOARD_SLOT_DEF = 7;

	// Input mode codes
	localparam logic [2:0] MODE_CREATE = 3'd0;
	localparam logic [2:0] MODE_LOCK   = 3'd1;
	localparam logic [2:0] MODE_CLEAR  = 3'd2;
	localparam logic [2:0] MODE_CHECK  = 3'd3;
	localparam logic [2:0] MODE_END    = 3'd4;

	// Slot field value that addresses the response slot
	localparam logic [3:0] RESPONSE_SEL = 4'd8;

	// Client slot status codes (code 3 unused, treated as empty)
	localparam logic [1:0] ST_EMPTY = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_LOCK  = 2'd2;

	// Classified operation passed from front to back
	typedef enum logic [2:0] {
		OP_NOP,
		OP_CREATE_CLIENT,
		OP_CREATE_RESP,
		OP_LOCK,
		OP_CLEAR,
		OP_CHECK,
		OP_END
	} op_t;

	// Frame source reported with each result
	typedef enum logic [1:0] {
		SRC_NONE,
		SRC_ONBOARD,
		SRC_RESPONSE,
		SRC_CLIENT
	} src_t;

	// Back-end sequencer states
	typedef enum logic {
		B_IDLE,
		B_SCAN
	} back_state_t;

	// Input transaction
	typedef struct packed {
		logic [2:0] mode;
		logic [3:0] slot;
		logic       select_high;
		logic       onboard_idle;
	} in_t;

	// Result transaction
	typedef struct packed {
		logic       ready_to_send;
		src_t       source;
		logic [2:0] chosen_slot;
		logic       send_complete;
		logic       create_refused;
		logic       busy_res;
	} out_t;

	// Queue entry
	typedef struct packed {
		op_t        op;
		logic [3:0] slot;
		logic       select_high;
		logic       onboard_idle;
	} cmd_t;

	// A slot holds a frame when full or locked
	function automatic logic has_frame(input logic [1:0] st);
		return (st == ST_FULL) || (st == ST_LOCK);
	endfunction

endpackage

// ===== rtl/core/sfa_front.sv =====
// ----------------------------------------------------------------------------
// sfa_front - input side of the slot arbiter
// Accepts input transactions, range checks the slot field and turns the mode
// into an operation code for the command queue.
// ----------------------------------------------------------------------------
module sfa_front import sfa_pkg::*; #(
	parameter int CLIENT_SLOTS = CLIENT_SLOTS_DEF
) (
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	input  logic q_full,
	output logic push,
	output cmd_t cmd
);

	logic slot_ok;

	// Handshake: take a transaction whenever the queue has room
	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;
	assign slot_ok  = 32'(in_data.slot) < 32'(CLIENT_SLOTS);

	// Classify
	always_comb begin
		cmd.slot         = in_data.slot;
		cmd.select_high  = in_data.select_high;
		cmd.onboard_idle = in_data.onboard_idle;
		unique case (in_data.mode)
			MODE_CREATE: begin
				if (in_data.slot == RESPONSE_SEL) begin
					cmd.op = OP_CREATE_RESP;
				end else if (slot_ok) begin
					cmd.op = OP_CREATE_CLIENT;
				end else begin
					cmd.op = OP_NOP;
				end
			end
			MODE_LOCK:  cmd.op = slot_ok ? OP_LOCK : OP_NOP;
			MODE_CLEAR: cmd.op = slot_ok ? OP_CLEAR : OP_NOP;
			MODE_CHECK: cmd.op = OP_CHECK;
			MODE_END:   cmd.op = OP_END;
			default:    cmd.op = OP_NOP;
		endcase
	end

endmodule

// ===== rtl/core/sfa_queue.sv =====
// ----------------------------------------------------------------------------
// sfa_queue - two-entry command queue
// Decouples the input side from the back-end sequencer.
// ----------------------------------------------------------------------------
module sfa_queue import sfa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic full,
	output logic empty,
	output cmd_t head
);

	cmd_t       mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head  = mem[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= push_cmd;
	end

endmodule

// ===== rtl/core/sfa_back.sv =====
// ----------------------------------------------------------------------------
// sfa_back - slot state and execution of queued operations
// Holds slot status, response flag, round-robin pointer, busy and RTS.
// Runs one operation per cycle unless the result is held; a check-ready
// that falls through to the sensor slots walks them one slot a cycle.
// ----------------------------------------------------------------------------
module sfa_back import sfa_pkg::*; #(
	parameter int CLIENT_SLOTS = CLIENT_SLOTS_DEF,
	parameter int SENSOR_SLOTS = SENSOR_SLOTS_DEF,
	parameter int ONBOARD_SLOT = ONBOARD_SLOT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  cmd_t head,
	output logic pop,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	localparam int IDX_W  = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
	localparam int RR_W   = (SENSOR_SLOTS > 1) ? $clog2(SENSOR_SLOTS) : 1;
	localparam int SEL_W  = (IDX_W > RR_W) ? IDX_W : RR_W;
	localparam bit OB_IN  = ONBOARD_SLOT < CLIENT_SLOTS;
	localparam int OB_POS = OB_IN ? ONBOARD_SLOT : 0;
	localparam logic [RR_W-1:0] RR_LAST = RR_W'(SENSOR_SLOTS - 1);

	back_state_t     state_q, state_d;
	logic [1:0]      status_q [CLIENT_SLOTS];
	logic            resp_q, resp_d;
	logic [RR_W-1:0] rr_q, rr_d;
	logic [RR_W-1:0] cnt_q, cnt_d;
	logic            busy_q, busy_d;
	logic            rts_q, rts_d;
	logic            out_valid_q;
	out_t            out_q, out_d;
	logic            out_load;
	logic            out_free;
	logic [RR_W-1:0] ptr_next;
	logic [SEL_W-1:0] rd_addr;
	logic [1:0]      rd_status;
	logic            ob_full;
	logic            wr_en;
	logic [SEL_W-1:0] wr_addr;
	logic [1:0]      wr_val;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || out_ready;

	// Round-robin step and status reads
	assign ptr_next  = (rr_q == RR_LAST) ? '0 : rr_q + RR_W'(1);
	assign rd_addr   = (state_q == B_IDLE && head.op == OP_CREATE_CLIENT) ? SEL_W'(head.slot)
		: ((state_q == B_SCAN) ? SEL_W'(ptr_next) : SEL_W'(rr_q));
	assign rd_status = (32'(rd_addr) < 32'(CLIENT_SLOTS)) ? status_q[rd_addr[IDX_W-1:0]]
		: ST_EMPTY;
	assign ob_full   = OB_IN && (status_q[IDX_W'(OB_POS)] == ST_FULL);

	// Sequencer: next state, state updates and result
	always_comb begin
		state_d  = state_q;
		resp_d   = resp_q;
		rr_d     = rr_q;
		cnt_d    = cnt_q;
		busy_d   = busy_q;
		rts_d    = rts_q;
		pop      = 1'b0;
		out_load = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = rd_addr;
		wr_val   = ST_EMPTY;
		out_d    = '0;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty && out_free) begin
					pop      = 1'b1;
					out_load = 1'b1;
					case (head.op)
						OP_CREATE_RESP: resp_d = 1'b1;
						OP_CREATE_CLIENT: begin
							if (rd_status == ST_LOCK) begin
								out_d.create_refused = 1'b1;
							end else begin
								wr_en  = 1'b1;
								wr_val = ST_FULL;
							end
						end
						OP_LOCK: begin
							wr_en   = 1'b1;
							wr_addr = SEL_W'(head.slot);
							wr_val  = ST_LOCK;
						end
						OP_CLEAR: begin
							wr_en   = 1'b1;
							wr_addr = SEL_W'(head.slot);
							wr_val  = ST_EMPTY;
							busy_d  = 1'b0;
						end
						OP_CHECK: begin
							if (!busy_q && head.select_high) begin
								if (ob_full) begin
									out_d.source = SRC_ONBOARD;
									busy_d       = 1'b1;
									rts_d        = 1'b1;
								end else if (resp_q) begin
									out_d.source = SRC_RESPONSE;
									busy_d       = 1'b1;
									rts_d        = 1'b1;
								end else begin
									// fall through to the sensor walk
									out_load = 1'b0;
									cnt_d    = '0;
									state_d  = B_SCAN;
								end
							end
						end
						OP_END: begin
							if (ob_full) begin
								wr_en               = 1'b1;
								wr_addr             = SEL_W'(OB_POS);
								out_d.send_complete = 1'b1;
							end else if (head.onboard_idle) begin
								if (resp_q) begin
									resp_d = 1'b0;
								end else if (has_frame(rd_status)) begin
									wr_en = 1'b1;
								end
							end
							busy_d = 1'b0;
							rts_d  = 1'b0;
						end
						default: ;
					endcase
				end
			end
			B_SCAN: begin
				// one sensor slot per cycle, pointer advances before the test
				rr_d  = ptr_next;
				cnt_d = cnt_q + RR_W'(1);
				if (has_frame(rd_status)) begin
					out_load          = 1'b1;
					out_d.source      = SRC_CLIENT;
					out_d.chosen_slot = 3'(ptr_next);
					busy_d            = 1'b1;
					rts_d             = 1'b1;
					state_d           = B_IDLE;
				end else if (cnt_q == RR_LAST) begin
					out_load = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
		out_d.ready_to_send = rts_d;
		out_d.busy_res      = busy_d;
	end

	// Control and arbitration state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			resp_q      <= 1'b0;
			rr_q        <= '0;
			cnt_q       <= '0;
			busy_q      <= 1'b1;
			rts_q       <= 1'b1;
			out_valid_q <= 1'b0;
			for (int i = 0; i < CLIENT_SLOTS; i++) status_q[i] <= ST_EMPTY;
		end else begin
			state_q <= state_d;
			resp_q  <= resp_d;
			rr_q    <= rr_d;
			cnt_q   <= cnt_d;
			busy_q  <= busy_d;
			rts_q   <= rts_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (wr_en && (32'(wr_addr) < 32'(CLIENT_SLOTS))) begin
				status_q[wr_addr[IDX_W-1:0]] <= wr_val;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (out_load) out_q <= out_d;
	end

`ifndef SYNTH
	a_scan_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_SCAN |-> !out_valid_q)
		else $error("sensor walk running with a result pending");

	a_rr_range: assert property (@(posedge clk) disable iff (!arst_n)
		rr_q <= RR_LAST)
		else $error("round-robin pointer out of range");

	a_pick_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && out_d.source != SRC_NONE |=> busy_q && rts_q)
		else $error("frame picked without busy and RTS");

	a_end_frees: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head.op == OP_END |=> !busy_q && !rts_q && out_valid_q)
		else $error("transfer end did not free the transmitter");
`endif

endmodule

// ===== rtl/core/spi_tx_frame_slot_arbiter_top.sv =====
// ----------------------------------------------------------------------------
// spi_tx_frame_slot_arbiter_top - SPI transmit frame slot arbiter
// Path: a result passes through the two-entry queue and the result register;
// a check-ready that searches the sensor slots tests up to SENSOR_SLOTS
// of them, paced by the one-slot-a-cycle round-robin walk.
// Throughput: one transaction per cycle otherwise while results are taken.
// Reset: all slots empty, response empty, pointer zero, busy and RTS set.
// ----------------------------------------------------------------------------
module spi_tx_frame_slot_arbiter_top import sfa_pkg::*; #(
	parameter int CLIENT_SLOTS = CLIENT_SLOTS_DEF,
	parameter int SENSOR_SLOTS = SENSOR_SLOTS_DEF,
	parameter int ONBOARD_SLOT = ONBOARD_SLOT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	logic q_full;
	logic q_empty;
	logic push;
	logic pop;
	cmd_t push_cmd;
	cmd_t head;

	// Front: accept and classify
	sfa_front #(
		.CLIENT_SLOTS(CLIENT_SLOTS)
	) u_front (
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data (in_data),
		.q_full  (q_full),
		.push    (push),
		.cmd     (push_cmd)
	);

	// Command queue
	sfa_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.full    (q_full),
		.empty   (q_empty),
		.head    (head)
	);

	// Back: slot state and execution
	sfa_back #(
		.CLIENT_SLOTS(CLIENT_SLOTS),
		.SENSOR_SLOTS(SENSOR_SLOTS),
		.ONBOARD_SLOT(ONBOARD_SLOT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.head     (head),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the SPI transmit frame slot arbiter
// Drives slot transactions (create, lock, clear, check-ready, transfer-end)
// through the valid/ready input channel. Each accepted transaction is run
// through a local model of the slot store, the round-robin pointer, the busy
// flag and the RTS line, and every result transaction is checked against it.
// A short directed part is followed by random frame rounds with noise. Both
// channels idle at random, and the receiver holds off for one long stretch.
// ----------------------------------------------------------------------------
module testbench import sfa_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLIENT_SLOTS   = CLIENT_SLOTS_DEF;
	localparam int SENSOR_SLOTS   = SENSOR_SLOTS_DEF;
	localparam int ONBOARD_SLOT   = ONBOARD_SLOT_DEF;
	localparam int MODE_MAX       = 7;       // largest value of the 3-bit mode field
	localparam int SLOT_FIELD_MAX = 15;      // largest value of the 4-bit slot field
	localparam int RANDOM_ITEMS   = 1850;
	localparam int SETTLE_CYCLES  = SENSOR_SLOTS + 16;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int REPORT_LIMIT   = 10;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t  in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;

	// Local copy of the arbiter state
	logic [1:0]  slot_st [CLIENT_SLOTS];
	logic        resp_full;
	int unsigned rr_pos;
	logic        tx_busy_m;
	logic        rts_m;

	out_t expected_q [$];

	int items_sent;
	int results_seen;
	int mismatches;
	int burst_left;
	bit gaps_on;
	int hold_req;
	int cycle_count;
	int picks [4];
	int refused_seen;
	int completes_seen;

	spi_tx_frame_slot_arbiter_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one transaction to the local state and return the result it should give
	function automatic out_t predict_slot_event(in_t c);
		out_t r;
		src_t src;
		int unsigned chosen;
		logic done_ob;
		logic refused;
		src     = SRC_NONE;
		chosen  = 0;
		done_ob = 1'b0;
		refused = 1'b0;
		case (c.mode)
			MODE_CREATE: begin
				if (c.slot == RESPONSE_SEL) begin
					resp_full = 1'b1;
				end else if (c.slot < CLIENT_SLOTS) begin
					if (slot_st[c.slot] == ST_LOCK)
						refused = 1'b1;
					else
						slot_st[c.slot] = ST_FULL;
				end
			end
			MODE_LOCK: begin
				if (c.slot < CLIENT_SLOTS)
					slot_st[c.slot] = ST_LOCK;
			end
			MODE_CLEAR: begin
				if (c.slot < CLIENT_SLOTS) begin
					slot_st[c.slot] = ST_EMPTY;
					tx_busy_m = 1'b0;
				end
			end
			MODE_CHECK: begin
				if (!tx_busy_m && c.select_high) begin
					if (slot_st[ONBOARD_SLOT] == ST_FULL) begin
						src = SRC_ONBOARD;
					end else if (resp_full) begin
						src = SRC_RESPONSE;
					end else begin
						// walk the sensor slots, pointer advances before each test
						for (int n = 0; n < SENSOR_SLOTS && src == SRC_NONE; n++) begin
							rr_pos = (rr_pos >= SENSOR_SLOTS - 1) ? 0 : rr_pos + 1;
							if (slot_st[rr_pos] == ST_FULL || slot_st[rr_pos] == ST_LOCK) begin
								src    = SRC_CLIENT;
								chosen = rr_pos;
							end
						end
					end
					if (src != SRC_NONE) begin
						tx_busy_m = 1'b1;
						rts_m     = 1'b1;
					end
				end
			end
			MODE_END: begin
				if (slot_st[ONBOARD_SLOT] == ST_FULL) begin
					slot_st[ONBOARD_SLOT] = ST_EMPTY;
					done_ob = 1'b1;
				end else if (c.onboard_idle) begin
					if (resp_full)
						resp_full = 1'b0;
					else if (slot_st[rr_pos] == ST_FULL || slot_st[rr_pos] == ST_LOCK)
						slot_st[rr_pos] = ST_EMPTY;
				end
				tx_busy_m = 1'b0;
				rts_m     = 1'b0;
			end
			default: ;
		endcase
		r.ready_to_send  = rts_m;
		r.source         = src;
		r.chosen_slot    = 3'(chosen);
		r.send_complete  = done_ob;
		r.create_refused = refused;
		r.busy_res       = tx_busy_m;
		return r;
	endfunction

	function automatic in_t slot_cmd(logic [2:0] m, logic [3:0] s, logic sel, logic ob);
		in_t c;
		c.mode         = m;
		c.slot         = s;
		c.select_high  = sel;
		c.onboard_idle = ob;
		return c;
	endfunction

	// Offer one transaction; bursts and gaps are handled here
	task automatic send_cmd(input in_t cmd);
		if (gaps_on && burst_left == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 5)) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 90)
				: $urandom_range(1, 12);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= cmd;
		do @(posedge clk); while (!in_ready);
		expected_q.push_back(predict_slot_event(cmd));
		items_sent++;
		if (burst_left > 0)
			burst_left--;
	endtask

	// Stop offering and wait for every outstanding result
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	// Check-ready while busy, transfer-end with no transfer, empty search
	task automatic test_reset_behaviour();
		send_cmd(slot_cmd(MODE_CHECK, 4'd0, 1'b1, 1'b1));
		send_cmd(slot_cmd(MODE_END, 4'd0, 1'b1, 1'b1));
		send_cmd(slot_cmd(MODE_CHECK, 4'd0, 1'b1, 1'b1));
	endtask

	// Onboard before response before client, locked slots and refused creates
	task automatic test_frame_priority();
		send_cmd(slot_cmd(MODE_CREATE, 4'(ONBOARD_SLOT), 1'b0, 1'b0));
		send_cmd(slot_cmd(MODE_CREATE, RESPONSE_SEL, 1'b1, 1'b0));
		send_cmd(slot_cmd(MODE_CREATE, 4'd0, 1'b0, 1'b1));
		send_cmd(slot_cmd(MODE_CREATE, 4'd5, 1'b1, 1'b1));
		send_cmd(slot_cmd(MODE_CHECK, 4'd0, 1'b0, 1'b1));
		send_cmd(slot_cmd(MODE_CHECK, 4'd0, 1'b1, 1'b1));
		send_cmd(slot_cmd(MODE_CHECK, 4'd0, 1'b1, 1'b1));
		send_cmd(slot_cmd(MODE_END, 4'd0, 1'b1, 1'b1));
		send_cmd(slot_cmd(MODE_CHECK, 4'd0, 1'b1, 1'b0));
		send_cmd(slot_cmd(MODE_END, 4'd0, 1'b1, 1'b0));
		send_cmd(slot_cmd(MODE_END, 4'd0, 1'b1, 1'b1));
		send_cmd(slot_cmd(MODE_LOCK, 4'(ONBOARD_SLOT), 1'b0, 1'b0));
		send_cmd(slot_cmd(MODE_CHECK, 4'd0, 1'b1, 1'b1));
		send_cmd(slot_cmd(MODE_LOCK, 4'd5, 1'b1, 1'b0));
		send_cmd(slot_cmd(MODE_CREATE, 4'd5, 1'b0, 1'b1));
		send_cmd(slot_cmd(MODE_END, 4'd0, 1'b0, 1'b1));
	endtask

	// Out-of-range slots, lock of the response slot, spare mode codes
	task automatic test_ignored_requests();
		send_cmd(slot_cmd(MODE_CREATE, 4'(SLOT_FIELD_MAX), 1'b1, 1'b1));
		send_cmd(slot_cmd(MODE_LOCK, RESPONSE_SEL, 1'b1, 1'b1));
		send_cmd(slot_cmd(MODE_CLEAR, 4'(CLIENT_SLOTS + 1), 1'b1, 1'b1));
		for (int m = MODE_END + 1; m <= MODE_MAX; m++)
			send_cmd(slot_cmd(3'(m), 4'd3, 1'b1, 1'b1));
	endtask

	// Clear frees the transmitter, then the search wraps past the last sensor slot
	task automatic test_clear_and_wrap();
		send_cmd(slot_cmd(MODE_CLEAR, 4'(ONBOARD_SLOT), 1'b0, 1'b0));
		send_cmd(slot_cmd(MODE_CHECK, 4'd0, 1'b1, 1'b1));
		drain_results();
	endtask

	// One frame round: fill some slots, ask for a frame, end the transfer
	task automatic send_frame_round();
		int fill;
		fill = $urandom_range(0, 4);
		repeat (fill)
			send_cmd(slot_cmd(($urandom_range(0, 4) == 0) ? MODE_LOCK : MODE_CREATE,
				4'($urandom_range(0, RESPONSE_SEL)), 1'($urandom), 1'($urandom)));
		send_cmd(slot_cmd(MODE_CHECK, 4'($urandom), ($urandom_range(0, 7) != 0),
			1'($urandom)));
		if ($urandom_range(0, 3) == 0)
			send_cmd(slot_cmd(MODE_CHECK, 4'($urandom), 1'b1, 1'($urandom)));
		send_cmd(slot_cmd(MODE_END, 4'($urandom), 1'($urandom),
			($urandom_range(0, 3) != 0)));
		if ($urandom_range(0, 4) == 0)
			send_cmd(slot_cmd(MODE_CLEAR, 4'($urandom_range(0, CLIENT_SLOTS - 1)),
				1'($urandom), 1'($urandom)));
	endtask

	// Long receiver hold-off while the sender keeps offering, then a full drain
	task automatic test_backpressure();
		gaps_on  = 1'b0;
		hold_req = 400;
		repeat (8)
			send_frame_round();
		drain_results();
		gaps_on = 1'b1;
	endtask

	// Mostly well-formed frame rounds, the rest arbitrary transactions
	task automatic test_random_traffic();
		int start;
		in_t c;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			if ($urandom_range(0, 4) == 0) begin
				c.mode         = 3'($urandom_range(0, MODE_MAX));
				c.slot         = 4'($urandom_range(0, SLOT_FIELD_MAX));
				c.select_high  = 1'($urandom);
				c.onboard_idle = 1'($urandom);
				send_cmd(c);
			end else begin
				send_frame_round();
			end
		end
		drain_results();
	endtask

	// Receiver: stall pattern of its own, plus a counted hold-off on request
	initial begin : receiver
		int hold_left;
		int phase;
		logic [15:0] pattern;
		hold_left = 0;
		phase     = 0;
		pattern   = '1;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (phase == 0) begin
					case ($urandom_range(0, 3))
						0: pattern = '1;
						1: pattern = 16'($urandom);
						2: pattern = 16'($urandom) | 16'($urandom);
						default: pattern = 16'($urandom) & 16'($urandom);
					endcase
				end
				out_ready <= pattern[phase % 16];
				phase = (phase + 1) % 64;
			end
		end
	end

	// Compare each result transaction with the oldest prediction
	always @(posedge clk) begin : result_check
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result transaction %p at cycle %0d",
						out_data, cycle_count);
			end else begin
				want = expected_q.pop_front();
				picks[want.source]++;
				refused_seen   += want.create_refused;
				completes_seen += want.send_complete;
				if (out_data.ready_to_send  !== want.ready_to_send  ||
				    out_data.source         !== want.source         ||
				    out_data.chosen_slot    !== want.chosen_slot    ||
				    out_data.send_complete  !== want.send_complete  ||
				    out_data.create_refused !== want.create_refused ||
				    out_data.busy_res       !== want.busy_res) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display({"mismatch on result %0d: rts %0b/%0b src %0d/%0d",
							" slot %0d/%0d complete %0b/%0b refused %0b/%0b busy %0b/%0b",
							" (expected/actual)"},
							results_seen,
							want.ready_to_send, out_data.ready_to_send,
							want.source, out_data.source,
							want.chosen_slot, out_data.chosen_slot,
							want.send_complete, out_data.send_complete,
							want.create_refused, out_data.create_refused,
							want.busy_res, out_data.busy_res);
				end
			end
		end
	end

	// Run limit
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding",
			cycle_count, expected_q.size());
		$display("testbench: FAIL");
		$finish;
	end

	// Test sequence
	initial begin : main
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_data        = '0;
		items_sent     = 0;
		results_seen   = 0;
		mismatches     = 0;
		burst_left     = 0;
		gaps_on        = 1'b1;
		hold_req       = 0;
		refused_seen   = 0;
		completes_seen = 0;
		picks          = '{default: 0};
		for (int i = 0; i < CLIENT_SLOTS; i++)
			slot_st[i] = ST_EMPTY;
		resp_full = 1'b0;
		rr_pos    = 0;
		tx_busy_m = 1'b1;
		rts_m     = 1'b1;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_behaviour();
		test_frame_priority();
		test_ignored_requests();
		test_clear_and_wrap();
		test_backpressure();
		test_random_traffic();

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("summary: %0d transactions sent, %0d results checked, %0d mismatches",
			items_sent, results_seen, mismatches);
		$display({"summary: picks onboard %0d response %0d client %0d,",
			" %0d refused creates, %0d onboard completions"},
			picks[SRC_ONBOARD], picks[SRC_RESPONSE], picks[SRC_CLIENT],
			refused_seen, completes_seen);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
